// ===== hw/rtl/sfss_pkg.sv =====
// sfss_pkg: constants, phase encoding and command opcodes for the flash sector sequencer
// used by spi_flash_sector_sequencer; no dependencies

package sfss_pkg;

    localparam int SECTOR_BYTES     = 4096;
    localparam int PAGE_BYTES       = 256;
    localparam int ADDR_BITS        = 24;

    localparam int SECTOR_SHIFT     = $clog2(SECTOR_BYTES);
    localparam int PAGES_PER_SECTOR = SECTOR_BYTES / PAGE_BYTES;
    localparam int PAGE_IDX_W       = $clog2(PAGES_PER_SECTOR) + 1;

    // field widths fixed by the word layout
    localparam int OP_W     = 2;
    localparam int SECTOR_W = 12;
    localparam int COUNT_W  = 13;
    localparam int REPLY_W  = 8;
    localparam int TICK_W   = 16;
    localparam int FADDR_W  = 24;
    localparam int SEND_W   = 9;
    localparam int RECV_W   = 13;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;

    typedef enum logic [1:0] {
        OP_START_WRITE = 2'd0,
        OP_START_READ  = 2'd1,
        OP_CMD_DONE    = 2'd2,
        OP_TICK        = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_W_CLEAR,
        PH_W_WAIT_PRE,
        PH_W_WREN_ERASE,
        PH_W_ERASE,
        PH_W_WAIT_ERASE,
        PH_W_WREN_PAGE,
        PH_W_PROG,
        PH_W_WAIT_PROG,
        PH_W_DISABLE,
        PH_R_WAIT,
        PH_R_READ
    } t_phase;

    localparam logic [7:0] OPC_CLEAR_EXT = 8'h82;
    localparam logic [7:0] OPC_READ_EXT  = 8'h81;
    localparam logic [7:0] OPC_WREN      = 8'h06;
    localparam logic [7:0] OPC_WRDI      = 8'h04;
    localparam logic [7:0] OPC_ERASE_4K  = 8'hD7;
    localparam logic [7:0] OPC_PROGRAM   = 8'h02;
    localparam logic [7:0] OPC_FAST_READ = 8'h0B;

    localparam logic [REPLY_W-1:0] STATUS_BUSY = 8'h01;
    localparam logic [REPLY_W-1:0] STATUS_ERR  = 8'h0E;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef struct packed {
        logic               is_finished;
        logic               failed;
        logic [7:0]         opcode;
        logic               has_address;
        logic [FADDR_W-1:0] flash_address;
        logic               dummy_count;
        logic [SEND_W-1:0]  send_bytes;
        logic [RECV_W-1:0]  receive_bytes;
    } t_result;

endpackage

// ===== hw/rtl/spi_flash_sector_sequencer.sv =====
// spi_flash_sector_sequencer: erase/program and read command sequencer for spi nor flash
// depends on sfss_pkg

// Takes one event word per cycle (start write, start read, command done, millisecond
// tick) and answers with at most one word: a command frame for the spi engine or a
// finished marker carrying the error flag. Each word is handled combinationally by the
// phase logic and its answer lands in an output register, so a new word is taken every
// cycle as long as the output register is empty or being drained in the same cycle.
// Each answer shows in the cycle after its word is accepted. The busy-poll timeout in
// ticks is set through the configuration write port and should only change while idle.
module spi_flash_sector_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [11:0] start_sector, [24:12] sector_count, [32:25] reply_byte, rest zero
    input  logic [sfss_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [1:0] op
    input  logic [sfss_pkg::OP_W-1:0]      i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] failed, [8:1] opcode, [9] has_address, [33:10] flash_address,
    // [34] dummy_count, [43:35] send_bytes, [56:44] receive_bytes, rest zero
    output logic [sfss_pkg::M_TDATA_W-1:0] o_m_tdata,
    // [0] is_finished
    output logic        o_m_tuser
);
    import sfss_pkg::*;

    logic [TICK_W-1:0]     r_timeout;
    t_phase                r_phase,       n_phase;
    logic                  r_is_write,    n_is_write;
    logic [ADDR_BITS-1:0]  r_cur_address, n_cur_address;
    logic [COUNT_W-1:0]    r_sectors_left, n_sectors_left;
    logic [PAGE_IDX_W-1:0] r_page_index,  n_page_index;
    logic [TICK_W-1:0]     r_elapsed,     n_elapsed;
    logic [REPLY_W-1:0]    r_last_status, n_last_status;
    logic                  r_poll_pending, n_poll_pending;
    logic                  r_error_seen,  n_error_seen;

    logic                  r_m_valid;
    t_result               r_result, n_result;
    logic                  emit;

    logic                  accept;
    t_op                   in_op;
    logic [SECTOR_W-1:0]   in_sector;
    logic [COUNT_W-1:0]    in_count;
    logic [REPLY_W-1:0]    in_reply;
    logic                  in_wait;
    logic [ADDR_BITS-1:0]  start_addr;
    logic [COUNT_W-1:0]    sectors_dec;
    logic                  err_now;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    assign in_op     = t_op'(i_s_tuser);
    assign in_sector = i_s_tdata[11:0];
    assign in_count  = i_s_tdata[24:12];
    assign in_reply  = i_s_tdata[32:25];

    assign start_addr  = ADDR_BITS'(in_sector) << SECTOR_SHIFT;
    assign sectors_dec = (r_sectors_left != '0) ? r_sectors_left - 1'b1 : r_sectors_left;
    assign in_wait     = (r_phase == PH_W_WAIT_PRE) || (r_phase == PH_W_WAIT_ERASE) ||
                         (r_phase == PH_W_WAIT_PROG) || (r_phase == PH_R_WAIT);
    assign err_now     = (in_reply & STATUS_ERR) != '0;

    always_comb begin
        n_phase        = r_phase;
        n_is_write     = r_is_write;
        n_cur_address  = r_cur_address;
        n_sectors_left = r_sectors_left;
        n_page_index   = r_page_index;
        n_elapsed      = r_elapsed;
        n_last_status  = r_last_status;
        n_poll_pending = r_poll_pending;
        n_error_seen   = r_error_seen;
        n_result       = '0;
        emit           = 1'b0;

        case (in_op)
            OP_START_WRITE, OP_START_READ: begin
                if (r_phase == PH_IDLE) begin
                    emit           = 1'b1;
                    n_cur_address  = start_addr;
                    n_sectors_left = in_count;
                    n_page_index   = '0;
                    n_error_seen   = 1'b0;
                    if (in_op == OP_START_WRITE) begin
                        n_is_write        = 1'b1;
                        n_poll_pending    = 1'b0;
                        n_phase           = PH_W_CLEAR;
                        n_result.opcode   = OPC_CLEAR_EXT;
                    end else begin
                        n_is_write              = 1'b0;
                        n_phase                 = PH_R_WAIT;
                        n_elapsed               = '0;
                        n_poll_pending          = 1'b1;
                        n_result.opcode         = OPC_READ_EXT;
                        n_result.receive_bytes  = RECV_W'(1);
                    end
                end
            end
            OP_TICK: begin
                if (in_wait && !r_poll_pending) begin
                    emit                   = 1'b1;
                    n_elapsed              = r_elapsed + 1'b1;
                    n_poll_pending         = 1'b1;
                    n_result.opcode        = OPC_READ_EXT;
                    n_result.receive_bytes = RECV_W'(1);
                end
            end
            OP_CMD_DONE: begin
                if (in_wait) begin
                    if (r_poll_pending) begin
                        n_poll_pending = 1'b0;
                        n_last_status  = in_reply;
                        // still busy and time left: wait for the next tick
                        if (!(in_reply[0] && (r_elapsed < r_timeout))) begin
                            emit = 1'b1;
                            if (r_phase == PH_R_WAIT) begin
                                if (r_sectors_left == '0) begin
                                    n_phase              = PH_IDLE;
                                    n_result.is_finished = 1'b1;
                                end else begin
                                    n_phase                = PH_R_READ;
                                    n_result.opcode        = OPC_FAST_READ;
                                    n_result.has_address   = 1'b1;
                                    n_result.dummy_count   = 1'b1;
                                    n_result.receive_bytes = RECV_W'(SECTOR_BYTES);
                                end
                            end else if (err_now) begin
                                n_error_seen    = 1'b1;
                                n_phase         = PH_W_DISABLE;
                                n_result.opcode = OPC_WRDI;
                            end else if (r_phase == PH_W_WAIT_PRE) begin
                                n_phase         = PH_W_WREN_ERASE;
                                n_result.opcode = OPC_WREN;
                            end else if (r_phase == PH_W_WAIT_ERASE) begin
                                n_page_index    = '0;
                                n_phase         = PH_W_WREN_PAGE;
                                n_result.opcode = OPC_WREN;
                            end else begin
                                n_page_index = r_page_index + 1'b1;
                                if (n_page_index < PAGE_IDX_W'(PAGES_PER_SECTOR)) begin
                                    n_phase         = PH_W_WREN_PAGE;
                                    n_result.opcode = OPC_WREN;
                                end else begin
                                    n_sectors_left = sectors_dec;
                                    if (sectors_dec != '0) begin
                                        n_phase                = PH_W_WAIT_PRE;
                                        n_elapsed              = '0;
                                        n_poll_pending         = 1'b1;
                                        n_result.opcode        = OPC_READ_EXT;
                                        n_result.receive_bytes = RECV_W'(1);
                                    end else begin
                                        n_phase         = PH_W_DISABLE;
                                        n_result.opcode = OPC_WRDI;
                                    end
                                end
                            end
                        end
                    end
                end else begin
                    case (r_phase)
                        PH_W_CLEAR: begin
                            emit = 1'b1;
                            if (r_sectors_left == '0) begin
                                n_phase         = PH_W_DISABLE;
                                n_result.opcode = OPC_WRDI;
                            end else begin
                                n_phase                = PH_W_WAIT_PRE;
                                n_elapsed              = '0;
                                n_poll_pending         = 1'b1;
                                n_result.opcode        = OPC_READ_EXT;
                                n_result.receive_bytes = RECV_W'(1);
                            end
                        end
                        PH_W_WREN_ERASE: begin
                            emit                 = 1'b1;
                            n_phase              = PH_W_ERASE;
                            n_result.opcode      = OPC_ERASE_4K;
                            n_result.has_address = 1'b1;
                        end
                        PH_W_ERASE: begin
                            emit                   = 1'b1;
                            n_phase                = PH_W_WAIT_ERASE;
                            n_elapsed              = '0;
                            n_poll_pending         = 1'b1;
                            n_result.opcode        = OPC_READ_EXT;
                            n_result.receive_bytes = RECV_W'(1);
                        end
                        PH_W_WREN_PAGE: begin
                            emit                 = 1'b1;
                            n_phase              = PH_W_PROG;
                            n_result.opcode      = OPC_PROGRAM;
                            n_result.has_address = 1'b1;
                            n_result.send_bytes  = SEND_W'(PAGE_BYTES);
                        end
                        PH_W_PROG: begin
                            emit                   = 1'b1;
                            n_cur_address          = r_cur_address + ADDR_BITS'(PAGE_BYTES);
                            n_phase                = PH_W_WAIT_PROG;
                            n_elapsed              = '0;
                            n_poll_pending         = 1'b1;
                            n_result.opcode        = OPC_READ_EXT;
                            n_result.receive_bytes = RECV_W'(1);
                        end
                        PH_W_DISABLE: begin
                            emit                 = 1'b1;
                            n_phase              = PH_IDLE;
                            n_result.is_finished = 1'b1;
                            n_result.failed      = r_error_seen;
                        end
                        PH_R_READ: begin
                            emit           = 1'b1;
                            n_cur_address  = r_cur_address + ADDR_BITS'(SECTOR_BYTES);
                            n_sectors_left = sectors_dec;
                            if (sectors_dec == '0) begin
                                n_phase              = PH_IDLE;
                                n_result.is_finished = 1'b1;
                            end else begin
                                n_phase                = PH_R_READ;
                                n_result.opcode        = OPC_FAST_READ;
                                n_result.has_address   = 1'b1;
                                n_result.dummy_count   = 1'b1;
                                n_result.receive_bytes = RECV_W'(SECTOR_BYTES);
                            end
                        end
                        default: begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        // address frames carry the address as it stands after this word
        if (n_result.has_address) begin
            n_result.flash_address = FADDR_W'(n_cur_address);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout      <= TIMEOUT_RESET;
            r_phase        <= PH_IDLE;
            r_is_write     <= 1'b0;
            r_cur_address  <= '0;
            r_sectors_left <= '0;
            r_page_index   <= '0;
            r_elapsed      <= '0;
            r_last_status  <= '0;
            r_poll_pending <= 1'b0;
            r_error_seen   <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (accept) begin
                r_phase        <= n_phase;
                r_is_write     <= n_is_write;
                r_cur_address  <= n_cur_address;
                r_sectors_left <= n_sectors_left;
                r_page_index   <= n_page_index;
                r_elapsed      <= n_elapsed;
                r_last_status  <= n_last_status;
                r_poll_pending <= n_poll_pending;
                r_error_seen   <= n_error_seen;
            end
            if (o_s_tready) begin
                r_m_valid <= accept && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_result.is_finished;
    assign o_m_tdata  = {7'd0,
                         r_result.receive_bytes,
                         r_result.send_bytes,
                         r_result.dummy_count,
                         r_result.flash_address,
                         r_result.has_address,
                         r_result.opcode,
                         r_result.failed};

endmodule
